// ===== sv/fiforr_pkg.sv =====
// Shared constants, codes and pointer helpers for the read/retire ring buffer.
// No dependencies; used by fiforr_ctrl, fiforr_dp and the top level.
package fiforr_pkg;

  // Ring size and stored payload width
  localparam int DEPTH         = 16;
  localparam int PAYLOAD_WIDTH = 64;

  // Fixed port widths
  localparam int PORT_W  = 64;
  localparam int MODE_W  = 2;
  localparam int COUNT_W = 5;

  // Pointers count modulo 2*DEPTH so that full and empty differ
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PTR_W    = ADDR_W + 1;
  localparam int PTR_SPAN = 2 * DEPTH;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RETIRE = 2'd2;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_DATA = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic start;  // execute the accepted item
    logic load;   // move the result into the output register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic out_free;  // output register empty or being taken this cycle
  } dp_stat_t;

  // Slot in the ring addressed by a pointer
  function automatic addr_t slot_of(ptr_t p);
    ptr_t s;
    s = (p >= PTR_W'(DEPTH)) ? p - PTR_W'(DEPTH) : p;
    return s[ADDR_W-1:0];
  endfunction

  // Pointer advanced by one, wrapping at 2*DEPTH
  function automatic ptr_t next_ptr(ptr_t p);
    return (p == PTR_W'(PTR_SPAN - 1)) ? '0 : p + 1'b1;
  endfunction

  // Number of entries between two pointers in ring order
  function automatic ptr_t distance(ptr_t ahead, ptr_t behind);
    return (ahead >= behind) ? ahead - behind
                             : ahead + PTR_W'(PTR_SPAN) - behind;
  endfunction

endpackage

// ===== sv/fiforr_ctrl.sv =====
// Sequencer for the read/retire ring buffer: accepts an item, then hands
// its result to the output register. Depends on fiforr_pkg.
module fiforr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  fiforr_pkg::dp_stat_t dp_stat,
  output fiforr_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_ACCEPT = 2'b01,
    S_LOAD   = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd.start  = 1'b0;
    cmd.load   = 1'b0;
    in_ready   = 1'b0;
    unique case (state)
      S_ACCEPT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (dp_stat.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_ACCEPT;
        end
      end
      default: state_next = S_ACCEPT;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/fiforr_dp.sv =====
// Datapath of the read/retire ring buffer: pointers, entry memory and the
// output register. Depends on fiforr_pkg.
module fiforr_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  fiforr_pkg::cmd_t                    cmd,
  output fiforr_pkg::dp_stat_t                dp_stat,
  input  logic [fiforr_pkg::MODE_W-1:0]       mode,
  input  logic [fiforr_pkg::PORT_W-1:0]       payload_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          status,
  output logic [fiforr_pkg::PORT_W-1:0]       payload_out,
  output logic [fiforr_pkg::COUNT_W-1:0]      unread_count
);

  fiforr_pkg::ptr_t wr_ptr, wr_ptr_next;
  fiforr_pkg::ptr_t rd_ptr, rd_ptr_next;
  fiforr_pkg::ptr_t rt_ptr, rt_ptr_next;

  logic [fiforr_pkg::PAYLOAD_WIDTH-1:0] mem [fiforr_pkg::DEPTH];
  logic [fiforr_pkg::PAYLOAD_WIDTH-1:0] rdata;
  fiforr_pkg::addr_t                    raddr;
  logic                                 mem_we;

  fiforr_pkg::status_t op_status, op_status_next;
  logic                op_data, op_data_next;

  fiforr_pkg::ptr_t                 used_cnt, unread_cnt, read_cnt;
  logic [fiforr_pkg::COUNT_W-1:0]   unread_low;
  logic [fiforr_pkg::COUNT_W-1:0]   unread_q;

  assign used_cnt   = fiforr_pkg::distance(wr_ptr, rt_ptr);
  assign unread_cnt = fiforr_pkg::distance(wr_ptr, rd_ptr);
  assign read_cnt   = fiforr_pkg::distance(rd_ptr, rt_ptr);

  // Decode the item against the current pointers
  always_comb begin
    wr_ptr_next    = wr_ptr;
    rd_ptr_next    = rd_ptr;
    rt_ptr_next    = rt_ptr;
    op_status_next = fiforr_pkg::STAT_NO_DATA;
    op_data_next   = 1'b0;
    mem_we         = 1'b0;
    raddr          = fiforr_pkg::slot_of(rd_ptr);
    priority if (mode == fiforr_pkg::MODE_INSERT) begin
      if (used_cnt >= fiforr_pkg::PTR_W'(fiforr_pkg::DEPTH)) begin
        op_status_next = fiforr_pkg::STAT_FULL;
      end else begin
        mem_we         = cmd.start;
        wr_ptr_next    = fiforr_pkg::next_ptr(wr_ptr);
        op_status_next = fiforr_pkg::STAT_OK;
      end
    end else if (mode == fiforr_pkg::MODE_READ) begin
      if (unread_cnt != '0) begin
        rd_ptr_next    = fiforr_pkg::next_ptr(rd_ptr);
        op_status_next = fiforr_pkg::STAT_OK;
        op_data_next   = 1'b1;
      end
    end else if (mode == fiforr_pkg::MODE_RETIRE) begin
      raddr = fiforr_pkg::slot_of(rt_ptr);
      if (read_cnt != '0) begin
        rt_ptr_next    = fiforr_pkg::next_ptr(rt_ptr);
        op_status_next = fiforr_pkg::STAT_OK;
        op_data_next   = 1'b1;
      end
    end else begin
      op_status_next = fiforr_pkg::STAT_NO_DATA;
    end
  end

  // Entry memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fiforr_pkg::slot_of(wr_ptr)] <= payload_in[fiforr_pkg::PAYLOAD_WIDTH-1:0];
    end
    if (cmd.start) begin
      rdata <= mem[raddr];
    end
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      rt_ptr <= '0;
    end else if (cmd.start) begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      rt_ptr <= rt_ptr_next;
    end
  end

  // Pending result of the item in flight
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_status <= op_status_next;
      op_data   <= op_data_next;
    end
  end

  // Output register; the count keeps only its low bits for a large ring
  assign unread_low = fiforr_pkg::COUNT_W'(unread_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status      <= op_status;
      payload_out <= op_data ? fiforr_pkg::PORT_W'(rdata) : '0;
      unread_q    <= unread_low;
    end
  end

  assign unread_count     = unread_q;
  assign dp_stat.out_free = !out_valid || out_ready;

  // Ring order: retire <= read <= write, at most DEPTH stored
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_cnt <= fiforr_pkg::PTR_W'(fiforr_pkg::DEPTH))
    else $error("stored entry count exceeds ring size");

  a_read_behind_write: assert property (@(posedge clk) disable iff (rst)
    read_cnt <= used_cnt)
    else $error("read pointer passed write pointer");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != fiforr_pkg::STAT_OK) |-> payload_out == '0)
    else $error("failed item carries nonzero payload");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!out_valid || out_ready))
    else $error("output register overwritten before taken");

endmodule

// ===== sv/fifo_with_read_and_retire_pointers.sv =====
// Ring buffer with one write pointer and two read pointers (read, retire).
// An insert appends at the tail (status full when DEPTH entries are stored),
// a read returns the oldest unread entry and leaves it stored, and a retire
// returns and frees the oldest entry that has already been read; an empty
// case or mode 3 answers no-data with a zero payload. Every item yields one
// result that also carries the count of unread entries after it. Each item
// is handled in steps: the pointers update and the entry memory is read
// (registered read port), then the result loads into the output register
// once it is free; the input takes no new item until that load. A finished
// result may wait in the output register while the next item is accepted.
// Depends on fiforr_pkg, fiforr_ctrl and fiforr_dp.
module fifo_with_read_and_retire_pointers (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [fiforr_pkg::MODE_W-1:0]   mode,
  input  logic [fiforr_pkg::PORT_W-1:0]   payload_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic [fiforr_pkg::PORT_W-1:0]   payload_out,
  output logic [fiforr_pkg::COUNT_W-1:0]  unread_count
);

  fiforr_pkg::cmd_t     cmd;
  fiforr_pkg::dp_stat_t dp_stat;

  fiforr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .dp_stat  (dp_stat),
    .cmd      (cmd)
  );

  fiforr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .dp_stat      (dp_stat),
    .mode         (mode),
    .payload_in   (payload_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .payload_out  (payload_out),
    .unread_count (unread_count)
  );

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for the read/retire ring buffer: directed table, then random mix.
// Depends on fiforr_pkg and fifo_with_read_and_retire_pointers.
module tb_top;
  import fiforr_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int WRAP = 2 * DEPTH;
  localparam logic [PORT_W-1:0] KEEP_MASK = {PORT_W{1'b1}} >> (PORT_W - PAYLOAD_WIDTH);
  localparam logic [PORT_W-1:0] ALL_ONES = {PORT_W{1'b1}};
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 80;
  localparam int HOLD_AFTER = 150;

  // One table row: an item and, where typed, the result it must give
  typedef struct {
    logic [MODE_W-1:0]  op;
    logic [PORT_W-1:0]  data;
    bit                 typed;
    status_t            st;
    logic [PORT_W-1:0]  res;
    logic [COUNT_W-1:0] cnt;
  } stim_row_t;

  typedef struct packed {
    status_t            st;
    logic [PORT_W-1:0]  data;
    logic [COUNT_W-1:0] cnt;
  } ring_result_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [MODE_W-1:0]   mode;
  logic [PORT_W-1:0]   payload_in;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          status;
  logic [PORT_W-1:0]   payload_out;
  logic [COUNT_W-1:0]  unread_count;

  // Shadow of the ring: stored payloads and the three positions, modulo 2*DEPTH
  logic [PORT_W-1:0] ring_mem [DEPTH];
  int unsigned       wr_pos, rd_pos, rt_pos;

  ring_result_t pending_results[$];
  ring_result_t oldest;
  stim_row_t    directed_rows[$];
  int           mismatch_count;
  int           results_taken;
  int           idle_cycles;
  bit           sender_calm;

  fifo_with_read_and_retire_pointers u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .payload_in   (payload_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .payload_out  (payload_out),
    .unread_count (unread_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Apply one item to the shadow ring and return the result it gives
  function automatic ring_result_t ring_apply(logic [MODE_W-1:0] op,
                                              logic [PORT_W-1:0] data);
    ring_result_t r;
    int unsigned  stored, unread, read_held;
    r.st      = STAT_NO_DATA;
    r.data    = '0;
    stored    = (wr_pos + WRAP - rt_pos) % WRAP;
    unread    = (wr_pos + WRAP - rd_pos) % WRAP;
    read_held = (rd_pos + WRAP - rt_pos) % WRAP;
    case (op)
      MODE_INSERT: begin
        if (stored >= DEPTH) begin
          r.st = STAT_FULL;
        end else begin
          ring_mem[wr_pos % DEPTH] = data & KEEP_MASK;
          wr_pos = (wr_pos + 1) % WRAP;
          r.st = STAT_OK;
        end
      end
      MODE_READ: begin
        if (unread != 0) begin
          r.data = ring_mem[rd_pos % DEPTH];
          rd_pos = (rd_pos + 1) % WRAP;
          r.st = STAT_OK;
        end
      end
      MODE_RETIRE: begin
        if (read_held != 0) begin
          r.data = ring_mem[rt_pos % DEPTH];
          rt_pos = (rt_pos + 1) % WRAP;
          r.st = STAT_OK;
        end
      end
      default: ;
    endcase
    r.data = r.data & KEEP_MASK;
    r.cnt  = COUNT_W'((wr_pos + WRAP - rd_pos) % WRAP);
    return r;
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Operation mix leaning toward filling or toward draining the ring
  function automatic logic [MODE_W-1:0] pick_op(bit fill_heavy);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return MODE_UNUSED;
    if (fill_heavy) begin
      if (r < 65) return MODE_INSERT;
      if (r < 88) return MODE_READ;
      return MODE_RETIRE;
    end
    if (r < 22) return MODE_INSERT;
    if (r < 62) return MODE_READ;
    return MODE_RETIRE;
  endfunction

  function automatic logic [PORT_W-1:0] pick_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return ALL_ONES;
    if (r < 16) return '0;
    return {$urandom, $urandom};
  endfunction

  // Offer one item, hold it until taken, then record the result it must give
  task automatic offer_item(input stim_row_t row);
    int           gap;
    ring_result_t r;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= row.op;
    payload_in <= row.data;
    do @(posedge clk); while (!in_ready);
    r = ring_apply(row.op, row.data);
    if (row.typed) r = '{row.st, row.res, row.cnt};
    pending_results.push_back(r);
  endtask

  // Result side: random ready bursts and stalls, plus one long hold-off
  initial begin
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (!held && results_taken >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat (($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12)) @(posedge clk);
        if (pick_gap() > 0) begin
          out_ready <= 1'b0;
          repeat (pick_gap() + 1) @(posedge clk);
        end
      end
    end
  end

  // Compare each result with the oldest one pending
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no item pending: status %0d payload_out %h", status, payload_out);
        mismatch_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (status !== oldest.st) begin
          $error("status: expected %0d, got %0d", oldest.st, status);
          mismatch_count++;
        end
        if (payload_out !== oldest.data) begin
          $error("payload_out: expected %h, got %h", oldest.data, payload_out);
          mismatch_count++;
        end
        if (unread_count !== oldest.cnt) begin
          $error("unread_count: expected %0d, got %0d", oldest.cnt, unread_count);
          mismatch_count++;
        end
      end
      results_taken++;
    end
  end

  // Watchdog on cycles where neither side moves an item
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t row;
    bit        fill_heavy;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    mode       <= MODE_INSERT;
    payload_in <= '0;
    mismatch_count = 0;
    results_taken  = 0;
    sender_calm    = 1'b0;
    wr_pos = 0;
    rd_pos = 0;
    rt_pos = 0;

    // Empty ring: every take fails, unused mode is ignored
    directed_rows.push_back('{MODE_READ,   '0,       1'b1, STAT_NO_DATA, '0, 5'd0});
    directed_rows.push_back('{MODE_RETIRE, '0,       1'b1, STAT_NO_DATA, '0, 5'd0});
    directed_rows.push_back('{MODE_UNUSED, ALL_ONES, 1'b1, STAT_NO_DATA, '0, 5'd0});
    // One entry through read then retire; retire before read is refused
    directed_rows.push_back('{MODE_INSERT, ALL_ONES, 1'b1, STAT_OK,      '0, 5'd1});
    directed_rows.push_back('{MODE_RETIRE, '0,       1'b1, STAT_NO_DATA, '0, 5'd1});
    directed_rows.push_back('{MODE_READ,   '0,       1'b1, STAT_OK, ALL_ONES, 5'd0});
    directed_rows.push_back('{MODE_READ,   '0,       1'b1, STAT_NO_DATA, '0, 5'd0});
    directed_rows.push_back('{MODE_RETIRE, '0,       1'b1, STAT_OK, ALL_ONES, 5'd0});
    // Fill all slots, then one insert too many
    for (int i = 0; i < DEPTH; i++) begin
      directed_rows.push_back('{MODE_INSERT,
                                (i % 2) ? 64'hAAAA_AAAA_AAAA_AAAA : 64'h5555_5555_5555_5555,
                                1'b0, STAT_OK, '0, '0});
    end
    directed_rows.push_back('{MODE_INSERT, 64'h1234, 1'b1, STAT_FULL, '0, 5'd16});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) offer_item(directed_rows[i]);

    // Random part: blocks alternate between filling and draining bias
    for (int blk = 0; blk < 10; blk++) begin
      fill_heavy  = (blk % 2 == 0);
      sender_calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 50; k++) begin
        row.op    = pick_op(fill_heavy);
        row.data  = pick_payload();
        row.typed = 1'b0;
        row.st    = STAT_OK;
        row.res   = '0;
        row.cnt   = '0;
        offer_item(row);
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
